[hw/rtl/mpca_pkg.sv]
package mpca_pkg;

  localparam int unsigned MaxPools         = 4;
  localparam int unsigned NumPoolsDefault  = 4;
  localparam int unsigned MaxChunksDefault = 256;
  localparam int unsigned QueueDepth       = 2;

  localparam int unsigned SizeW    = 16;
  localparam int unsigned CountW   = 9;
  localparam int unsigned PoolW    = 2;
  localparam int unsigned ChunkW   = 8;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  // register map: sizes first, then counts
  localparam logic [CfgIdxW-1:0] CfgSizeBase  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgCountBase = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgEnd       = 4'd8;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_REJECT
  } op_kind_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_EXHAUSTED,
    STATUS_RANGE
  } status_e;

  typedef struct packed {
    op_kind_e            kind;
    logic [MaxPools-1:0] fit;
    logic [PoolW-1:0]    pool;
    logic [ChunkW-1:0]   chunk;
  } op_t;

  typedef struct packed {
    status_e           status;
    logic [PoolW-1:0]  pool;
    logic [ChunkW-1:0] chunk;
  } res_t;

endpackage

[hw/rtl/multi_pool_chunk_allocator.sv]
// multi-pool chunk allocator
//
// requests enter through a queue interface: present action/size/pool/chunk
// and raise push_i; the item is taken on a clock edge with full_o low.
// results leave the same way: while empty_o is low the oldest result sits on
// status_o, granted_pool_o and granted_chunk_o, and pop_i takes it.
// pool sizes and counts are written through cfg_valid_i/cfg_index_i/cfg_data_i,
// always ready; write only while the block is idle (the block does not enforce it).
//
// a front end classifies each item (fitting pools, free range check) into a
// two-entry op queue; the back end owns the free lists and the link memory
// and drains results into a two-entry result queue.
// a result passes through the op queue and then the result queue before it
// shows on the outputs. frees, rejects and grants of never-used chunks let the
// back end take the next item at once; a grant off a freed list then waits
// in ST_LINK until the single link memory read lands and that pool's head moves.
// a stalled result side fills the result queue, then the op queue, and then
// full_o rises; nothing is dropped.
// reset empties every free list, rewinds the never-used counters and disables
// all pools; the link memory is not cleared and needs no sweep.
module multi_pool_chunk_allocator #(
  parameter int unsigned N_POOLS    = mpca_pkg::NumPoolsDefault,
  parameter int unsigned MAX_CHUNKS = mpca_pkg::MaxChunksDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request queue side
  input  logic                          push_i,
  output logic                          full_o,
  input  logic                          action_i,
  input  logic [mpca_pkg::SizeW-1:0]    request_size_i,
  input  logic [mpca_pkg::PoolW-1:0]    free_pool_i,
  input  logic [mpca_pkg::ChunkW-1:0]   free_chunk_i,
  // result queue side
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [1:0]                    status_o,
  output logic [mpca_pkg::PoolW-1:0]    granted_pool_o,
  output logic [mpca_pkg::ChunkW-1:0]   granted_chunk_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mpca_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mpca_pkg::CfgDataW-1:0] cfg_data_i
);

  import mpca_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);

  logic [SizeW-1:0] pool_size   [MaxPools];
  logic [CW-1:0]    pool_usable [MaxPools];

  // front to op queue
  logic             op_push, op_full;
  op_t              op_in;
  // op queue to back
  logic             op_pop, op_empty;
  logic [$bits(op_t)-1:0] op_raw;
  op_t              op_out;
  // back to result queue
  logic             res_push, res_full;
  res_t             res_in, res_out;
  logic [$bits(res_t)-1:0] res_raw;

  mpca_cfg #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .size_o      (pool_size),
    .usable_o    (pool_usable)
  );

  mpca_front #(
    .N_POOLS    (N_POOLS),
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_front (
    .push_i         (push_i),
    .full_o         (full_o),
    .action_i       (action_i),
    .request_size_i (request_size_i),
    .free_pool_i    (free_pool_i),
    .free_chunk_i   (free_chunk_i),
    .size_i         (pool_size),
    .usable_i       (pool_usable),
    .op_full_i      (op_full),
    .op_push_o      (op_push),
    .op_o           (op_in)
  );

  // decouples classification from list updates
  mpca_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (QueueDepth)
  ) u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .wdata_i (op_in),
    .full_o  (op_full),
    .pop_i   (op_pop),
    .rdata_o (op_raw),
    .empty_o (op_empty)
  );

  assign op_out = op_t'(op_raw);

  mpca_back #(
    .N_POOLS    (N_POOLS),
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (!op_empty),
    .op_i       (op_out),
    .op_pop_o   (op_pop),
    .usable_i   (pool_usable),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // output register stage; keeps the back end running while pop_i is low
  mpca_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (res_raw),
    .empty_o (empty_o)
  );

  assign res_out         = res_t'(res_raw);
  assign status_o        = res_out.status;
  assign granted_pool_o  = res_out.pool;
  assign granted_chunk_o = res_out.chunk;

endmodule

[hw/rtl/mpca_fifo.sv]
module mpca_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[hw/rtl/mpca_cfg.sv]
module mpca_cfg #(
  parameter int unsigned MAX_CHUNKS = mpca_pkg::MaxChunksDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mpca_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [mpca_pkg::CfgDataW-1:0]       cfg_data_i,
  output logic [mpca_pkg::SizeW-1:0]          size_o   [mpca_pkg::MaxPools],
  output logic [$clog2(MAX_CHUNKS + 1)-1:0]   usable_o [mpca_pkg::MaxPools]
);

  import mpca_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);

  logic [SizeW-1:0]   size_q  [MaxPools];
  logic [CountW-1:0]  count_q [MaxPools];
  logic [CfgIdxW-1:0] count_off;

  assign cfg_ready_o = 1'b1;
  assign count_off   = cfg_index_i - CfgCountBase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < MaxPools; p++) begin
        size_q[p]  <= '0;
        count_q[p] <= '0;
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i >= CfgSizeBase && cfg_index_i < CfgCountBase) begin
        size_q[cfg_index_i[1:0]] <= cfg_data_i;
      end else if (cfg_index_i >= CfgCountBase && cfg_index_i < CfgEnd) begin
        count_q[count_off[1:0]] <= cfg_data_i[CountW-1:0];
      end
    end
  end

  // count saturates at the pool capacity
  always_comb begin
    for (int p = 0; p < MaxPools; p++) begin
      size_o[p]   = size_q[p];
      usable_o[p] = (32'(count_q[p]) > MAX_CHUNKS) ? CW'(MAX_CHUNKS) : CW'(count_q[p]);
    end
  end

endmodule

[hw/rtl/mpca_front.sv]
module mpca_front #(
  parameter int unsigned N_POOLS    = mpca_pkg::NumPoolsDefault,
  parameter int unsigned MAX_CHUNKS = mpca_pkg::MaxChunksDefault
) (
  input  logic                              push_i,
  output logic                              full_o,
  input  logic                              action_i,
  input  logic [mpca_pkg::SizeW-1:0]        request_size_i,
  input  logic [mpca_pkg::PoolW-1:0]        free_pool_i,
  input  logic [mpca_pkg::ChunkW-1:0]       free_chunk_i,
  input  logic [mpca_pkg::SizeW-1:0]        size_i   [mpca_pkg::MaxPools],
  input  logic [$clog2(MAX_CHUNKS + 1)-1:0] usable_i [mpca_pkg::MaxPools],
  input  logic                              op_full_i,
  output logic                              op_push_o,
  output mpca_pkg::op_t                     op_o
);

  import mpca_pkg::*;

  logic free_bad;

  assign full_o    = op_full_i;
  assign op_push_o = push_i && !op_full_i;

  assign free_bad = (32'(free_pool_i) >= N_POOLS) || (size_i[free_pool_i] == '0) ||
                    (32'(free_chunk_i) >= 32'(usable_i[free_pool_i]));

  always_comb begin
    op_o.pool  = free_pool_i;
    op_o.chunk = free_chunk_i;
    // pools that could serve this request, ignoring their fill state
    for (int p = 0; p < MaxPools; p++) begin
      op_o.fit[p] = (p < N_POOLS) && (size_i[p] != '0) &&
                    (size_i[p] >= request_size_i) && (usable_i[p] != '0);
    end
    if (!action_i) begin
      op_o.kind = OP_ALLOC;
    end else if (free_bad) begin
      op_o.kind = OP_REJECT;
    end else begin
      op_o.kind = OP_FREE;
    end
  end

endmodule

[hw/rtl/mpca_back.sv]
module mpca_back #(
  parameter int unsigned N_POOLS    = mpca_pkg::NumPoolsDefault,
  parameter int unsigned MAX_CHUNKS = mpca_pkg::MaxChunksDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              op_valid_i,
  input  mpca_pkg::op_t                     op_i,
  output logic                              op_pop_o,
  input  logic [$clog2(MAX_CHUNKS + 1)-1:0] usable_i [mpca_pkg::MaxPools],
  input  logic                              res_full_i,
  output logic                              res_push_o,
  output mpca_pkg::res_t                    res_o
);

  import mpca_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned PW    = (N_POOLS > 1) ? $clog2(N_POOLS) : 1;
  localparam int unsigned Depth = N_POOLS * MAX_CHUNKS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [CW-1:0] EmptyMark = CW'(MAX_CHUNKS);

  typedef enum logic {
    ST_IDLE,
    ST_LINK
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   head_q   [N_POOLS];
  logic [CW-1:0]   unused_q [N_POOLS];
  logic [PW-1:0]   link_pool_q;
  logic [CW-1:0]   link_mem [Depth];
  logic [CW-1:0]   rdata_q;

  logic            go;
  logic            sel_found, sel_from_freed;
  logic [PW-1:0]   sel_pool, free_idx;
  logic [CW-1:0]   sel_chunk;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;

  // lowest pool with a chunk left wins
  always_comb begin
    sel_found      = 1'b0;
    sel_from_freed = 1'b0;
    sel_pool       = '0;
    sel_chunk      = '0;
    for (int p = N_POOLS - 1; p >= 0; p--) begin
      if (op_i.fit[p] && (head_q[p] != EmptyMark || unused_q[p] < usable_i[p])) begin
        sel_found      = 1'b1;
        sel_pool       = PW'(p);
        sel_from_freed = (head_q[p] != EmptyMark);
        sel_chunk      = (head_q[p] != EmptyMark) ? head_q[p] : unused_q[p];
      end
    end
  end

  assign free_idx   = PW'(op_i.pool);
  assign go         = (state_q == ST_IDLE) && op_valid_i && !res_full_i;
  assign op_pop_o   = go;
  assign res_push_o = go;

  assign mem_we    = go && (op_i.kind == OP_FREE);
  assign mem_re    = go && (op_i.kind == OP_ALLOC) && sel_found && sel_from_freed;
  assign mem_waddr = AW'(32'(free_idx) * MAX_CHUNKS + 32'(op_i.chunk));
  assign mem_raddr = AW'(32'(sel_pool) * MAX_CHUNKS + 32'(sel_chunk));

  always_comb begin
    res_o.status = STATUS_OK;
    res_o.pool   = '0;
    res_o.chunk  = '0;
    unique case (op_i.kind)
      OP_ALLOC: begin
        if (sel_found) begin
          res_o.pool  = PoolW'(sel_pool);
          res_o.chunk = ChunkW'(sel_chunk);
        end else begin
          res_o.status = STATUS_EXHAUSTED;
        end
      end
      OP_FREE: res_o.status = STATUS_OK;
      default: res_o.status = STATUS_RANGE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      link_pool_q <= '0;
      for (int p = 0; p < N_POOLS; p++) begin
        head_q[p]   <= EmptyMark;
        unused_q[p] <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (go) begin
            unique case (op_i.kind)
              OP_ALLOC: begin
                if (sel_found && sel_from_freed) begin
                  link_pool_q <= sel_pool;
                  state_q     <= ST_LINK;
                end else if (sel_found) begin
                  unused_q[sel_pool] <= unused_q[sel_pool] + 1'b1;
                end
              end
              OP_FREE: head_q[free_idx] <= CW'(op_i.chunk);
              default: ;
            endcase
          end
        end
        ST_LINK: begin
          // link word of the popped chunk becomes the new head
          head_q[link_pool_q] <= rdata_q;
          state_q             <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= head_q[free_idx];
    end
    if (mem_re) begin
      rdata_q <= link_mem[mem_raddr];
    end
  end

  a_read_enters_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> (state_q == ST_LINK))
    else $error("link read without head update cycle");

  a_link_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINK) |-> $past(mem_re))
    else $error("head update without link read");

  a_link_blocks_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINK) |-> (!op_pop_o && !res_push_o))
    else $error("operation taken while head update pending");

endmodule
